/* rtl/core/piq_pkg.sv */
// piq_pkg: shared types and codes for the positional insert queue.
// Used by every file of the block; depends on nothing.
package piq_pkg;

   localparam int POS_W = 8;
   localparam int WORD_W = 32;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BADPOS = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   localparam logic signed [WORD_W-1:0] NO_WORD = '1;

   typedef struct packed {
      logic                     action;
      logic signed [WORD_W-1:0] value_in;
      logic [POS_W-1:0]         position;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] value_out;
      logic [POS_W-1:0]         occupancy;
   } rsp_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                     ins;
      logic                     rem;
      logic [POS_W-1:0]         pos;
      logic signed [WORD_W-1:0] value;
   } cell_ctl_type;

endpackage

/* rtl/core/positional_insert_queue.sv */
// positional_insert_queue: ordered word queue with insert at any position.
// Depends on piq_pkg and piq_cell.
//
//   channel | direction | payload  | transaction
//   req     | in        | req_type | req_valid & req_ready
//   rsp     | out       | rsp_type | rsp_valid & rsp_ready
//
// One transaction per cycle while req_ready is high: on an insert, cells
// from the position on update in the accept cycle (all shift on a remove);
// the result is registered, shown the next cycle. req_ready is high while
// the result register is empty or draining. Synchronous reset clears the
// count and result valid; cell words stay undefined until written.
module positional_insert_queue import piq_pkg::*; #(
   parameter int DEPTH = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;
   cell_ctl_type             ctl;
   logic signed [WORD_W-1:0] cell_data [DEPTH];
   logic                     accept, full, bad_pos, empty;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;

   assign full = (32'(count_ff) == 32'(DEPTH));
   assign bad_pos = (32'(req_data.position) > 32'(count_ff));
   assign empty = (count_ff == '0);

   always_comb begin
      ctl.ins = 1'b0;
      ctl.rem = 1'b0;
      ctl.pos = req_data.position;
      ctl.value = req_data.value_in;
      count_in = count_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_in.value_out = NO_WORD;
         rsp_in.status = ST_OK;
         if (req_data.action == ACT_INSERT) begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else if (bad_pos) begin
               rsp_in.status = ST_BADPOS;
            end else begin
               ctl.ins = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               ctl.rem = 1'b1;
               rsp_in.value_out = cell_data[0];
               count_in = count_ff - CNT_W'(1);
            end
         end
         rsp_in.occupancy = POS_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [WORD_W-1:0] left_w, right_w;
      if (i == 0) begin : g_first
         assign left_w = NO_WORD;
      end else begin : g_left
         assign left_w = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_w = cell_data[i];
      end else begin : g_right
         assign right_w = cell_data[i+1];
      end
      piq_cell #(.IDX(i)) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .left_data (left_w),
         .right_data(right_w),
         .data      (cell_data[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

/* rtl/core/piq_cell.sv */
// piq_cell: one storage cell of the queue chain.
// Depends on piq_pkg; takes its neighbors' words and the broadcast control.
module piq_cell import piq_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic                     clock,
   input  cell_ctl_type             ctl,
   input  logic signed [WORD_W-1:0] left_data,
   input  logic signed [WORD_W-1:0] right_data,
   output logic signed [WORD_W-1:0] data
);

   localparam logic [31:0] IDX_L = 32'(IDX);

   logic signed [WORD_W-1:0] data_ff;
   logic signed [WORD_W-1:0] data_in;
   logic [31:0]              pos_ext;

   assign pos_ext = 32'(ctl.pos);

   always_comb begin
      data_in = data_ff;
      if (ctl.ins) begin
         if (pos_ext < IDX_L) begin
            data_in = left_data;
         end else if (pos_ext == IDX_L) begin
            data_in = ctl.value;
         end
      end else if (ctl.rem) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* rtl/core/piq_checker.sv */
// piq_port_checks: port-level checks for positional_insert_queue, bound to it.
// Depends on piq_pkg.
module piq_port_checks import piq_pkg::*; #(
   parameter int DEPTH = 128
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted transaction produced no result");

   a_refused_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.value_out == NO_WORD)
      else $error("refused transaction returned a word");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |-> rsp_data.occupancy == '0)
      else $error("empty status with nonzero occupancy");

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_data.occupancy) <= 32'(DEPTH))
      else $error("occupancy beyond depth");

endmodule

bind positional_insert_queue piq_port_checks #(.DEPTH(DEPTH)) u_piq_port_checks (.*);

/* tb/piq_checker.sv */
`timescale 1ns / 100ps
// piq_checker: monitors the req and rsp channels of positional_insert_queue, predicts every
// result from its own copy of the queue and compares it field by field.
// Depends on piq_pkg.
module piq_checker import piq_pkg::*; #(
   parameter int DEPTH = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      outstanding
);

   logic signed [WORD_W-1:0] shadow_words [DEPTH];
   int unsigned              shadow_count;
   rsp_type                  expected_rsps [$];
   int                       fail_total;

   function automatic rsp_type apply_transaction(input req_type r);
      rsp_type e;
      e.status    = ST_OK;
      e.value_out = NO_WORD;
      if (r.action == ACT_INSERT) begin
         if (shadow_count >= DEPTH) begin
            e.status = ST_FULL;
         end else if (r.position > shadow_count) begin
            e.status = ST_BADPOS;
         end else begin
            for (int k = int'(shadow_count); k > int'(r.position); k--)
               shadow_words[k] = shadow_words[k-1];
            shadow_words[r.position] = r.value_in;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            e.status = ST_EMPTY;
         end else begin
            e.value_out = shadow_words[0];
            for (int k = 0; k + 1 < int'(shadow_count); k++)
               shadow_words[k] = shadow_words[k+1];
            shadow_count--;
         end
      end
      e.occupancy = shadow_count[POS_W-1:0];
      return e;
   endfunction

   function automatic void flag(input string why, input rsp_type want, input rsp_type got);
      fail_total++;
      if (fail_total <= 10)
         $display("%0t: %s: expected status %0d value %0d occupancy %0d, got status %0d value %0d occupancy %0d",
                  $time, why, want.status, want.value_out, want.occupancy,
                  got.status, got.value_out, got.occupancy);
   endfunction

   initial begin
      fail_total     = 0;
      shadow_count   = 0;
      mismatch_count = 0;
      outstanding    = 0;
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         shadow_count = 0;
         expected_rsps.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               flag("unexpected transaction", '0, rsp_data);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status || rsp_data.value_out !== want.value_out ||
                   rsp_data.occupancy !== want.occupancy)
                  flag("mismatch", want, rsp_data);
            end
         end
         if (req_valid && req_ready)
            expected_rsps.push_back(apply_transaction(req_data));
      end
      mismatch_count <= fail_total;
      outstanding    <= expected_rsps.size();
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for positional_insert_queue; directed corner cases, then
// random fill/drain sequences under three idling regimes. Depends on piq_pkg and piq_checker.
module tb_top import piq_pkg::*; ();

   localparam int DEPTH       = 128;
   localparam int STALL_LIMIT = 2000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      mismatch_count;
   int      outstanding;

   int          tx_idle_pct;
   int          rx_idle_pct;
   int unsigned fill_estimate;
   bit          growing;

   positional_insert_queue #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   piq_checker #(.DEPTH(DEPTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic req_type make_req(input logic act, input logic signed [WORD_W-1:0] word,
                                        input logic [POS_W-1:0] pos);
      req_type r;
      r.action   = act;
      r.value_in = word;
      r.position = pos;
      return r;
   endfunction

   task automatic offer(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (item.action == ACT_INSERT) begin
         if (fill_estimate < DEPTH && item.position <= fill_estimate) fill_estimate++;
      end else if (fill_estimate > 0) begin
         fill_estimate--;
      end
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < tx_idle_pct);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // grow toward full, then shrink toward empty; a few positions are noise
   task automatic random_phase(input int count);
      req_type item;
      for (int n = 0; n < count; n++) begin
         if (growing && fill_estimate == DEPTH && $urandom_range(0, 3) == 0)
            growing = 1'b0;
         else if (!growing && fill_estimate == 0 && $urandom_range(0, 3) == 0)
            growing = 1'b1;
         item.value_in = $urandom;
         item.position = POS_W'($urandom_range(0, 255));
         if ($urandom_range(0, 99) < (growing ? 88 : 15)) begin
            item.action = ACT_INSERT;
            if ($urandom_range(0, 99) >= 8)
               item.position = POS_W'($urandom_range(0, fill_estimate));
         end else begin
            item.action = ACT_REMOVE;
         end
         offer(item);
      end
   endtask

   initial begin : stimulus
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      tx_idle_pct = 37;
      rx_idle_pct = 70;
      fill_estimate = 0;
      growing     = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer(make_req(ACT_REMOVE, $urandom, POS_W'($urandom)));
      offer(make_req(ACT_INSERT, 32'sh7FFF_FFFF, 8'd1));
      offer(make_req(ACT_INSERT, 32'sh7FFF_FFFF, 8'd0));
      offer(make_req(ACT_INSERT, 32'sh8000_0000, 8'd1));
      offer(make_req(ACT_INSERT, 32'sh0000_0000, 8'd0));
      offer(make_req(ACT_INSERT, -32'sd1, 8'd1));
      offer(make_req(ACT_INSERT, 32'sd5, 8'd5));
      offer(make_req(ACT_INSERT, 32'sd6, 8'd255));
      offer(make_req(ACT_INSERT, 32'sd7, 8'd128));
      offer(make_req(ACT_INSERT, 32'sh5A5A_5A5A, 8'd4));
      repeat (5) offer(make_req(ACT_REMOVE, $urandom, POS_W'($urandom)));
      offer(make_req(ACT_REMOVE, '1, '1));
      offer(make_req(ACT_INSERT, 32'sd1, 8'd0));
      offer(make_req(ACT_REMOVE, '1, '1));

      random_phase(230);
      drain();
      tx_idle_pct = 70;
      rx_idle_pct = 37;
      random_phase(230);
      drain();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      random_phase(230);
      drain();

      repeat (12) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // long hold-off once, so the result register backs up and req_ready drops
   initial begin : receiver
      int served;
      int hold;
      served = 0;
      hold   = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            served++;
            if (served == 300) hold = 64;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet == STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

endmodule
